FILE: rtl/r250_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the r250 lagged xor generator
// no dependencies

package r250_pkg;

  localparam int unsigned TableLen = 250;
  localparam int unsigned LagAhead = 103;
  localparam int unsigned DiagBase = 3;
  localparam int unsigned DiagStride = 11;
  localparam int unsigned DiagCount = 16;
  localparam int unsigned AddrW = $clog2(TableLen);

  localparam logic [31:0] LcgMul = 32'h015a_4e35;
  localparam logic [14:0] MarkThresh = 15'd16384;
  localparam logic [15:0] TopBit = 16'h8000;
  localparam logic [15:0] AllOnes = 16'hffff;

  localparam logic [1:0] ActReseed = 2'd0;
  localparam logic [1:0] ActRaw = 2'd1;
  localparam logic [1:0] ActBounded = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] bound;
  } in_item_t;

  typedef struct packed {
    logic [15:0] value;
    logic        bad_bound;
  } out_item_t;

endpackage

FILE: rtl/r250_random_generator.sv
`timescale 1ns / 1ps
// raw draw: table read, write back, then hand-off into the result register
// bounded draw: limit by radix-2 remainder unit, then attempts of two table steps each,
//   retried while the second word >= limit, then its remainder by the bound, then hand-off
// reseed: fill 250 words, random top bits, 16 diagonal words, hand-off; zero bound, spare action: hand-off
// one item at a time, next transfer in the cycle after the result register loads
// reset clears control state, table words read as zero until written; uses r250_pkg

module r250_random_generator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  r250_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output r250_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);

  import r250_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_FILL    = 10'b00_0000_0010,
    S_MARK_RD = 10'b00_0000_0100,
    S_MARK_WR = 10'b00_0000_1000,
    S_DIAG_RD = 10'b00_0001_0000,
    S_DIAG_WR = 10'b00_0010_0000,
    S_STEP_RD = 10'b00_0100_0000,
    S_STEP_WR = 10'b00_1000_0000,
    S_DIV     = 10'b01_0000_0000,
    S_DONE    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [15:0]      seed_q;
  logic [31:0]      lcg_q, lcg_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [3:0]       diag_q, diag_d;
  logic             bounded_q, bounded_d;
  logic             second_q, second_d;
  logic             div_mod_q, div_mod_d;
  logic [15:0]      bound_q, bound_d;
  logic [15:0]      limit_q, limit_d;
  logic [15:0]      div_rem_q, div_rem_d;
  logic [15:0]      div_dvd_q, div_dvd_d;
  logic [3:0]       div_cnt_q, div_cnt_d;
  out_item_t        res_q, res_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_data_q, out_data_d;

  // table memory with validity flags
  logic [15:0]         tbl_mem [TableLen];
  logic [TableLen-1:0] tbl_vld_q;
  logic [15:0]         rd_a_q, rd_b_q;
  logic                rd_a_vld_q, rd_b_vld_q;
  logic                wr_en;
  logic [AddrW-1:0]    wr_addr, rd_addr_a, rd_addr_b;
  logic [15:0]         wr_data;

  logic [15:0]   word_a, word_b, step_word;
  logic [31:0]   lcg_nxt;
  logic [14:0]   lcg_out;
  logic [AddrW:0] there_sum;
  logic [16:0]   rem_sh;
  logic [15:0]   rem_nxt;
  logic [15:0]   diag_keep, diag_top;

  assign word_a = rd_a_vld_q ? rd_a_q : '0;
  assign word_b = rd_b_vld_q ? rd_b_q : '0;
  assign step_word = word_a ^ word_b;

  assign lcg_nxt = lcg_q * LcgMul + 32'd1;
  assign lcg_out = lcg_nxt[30:16];

  assign there_sum = {1'b0, idx_q} + (AddrW+1)'(LagAhead);
  assign rd_addr_b = (there_sum >= (AddrW+1)'(TableLen))
                   ? AddrW'(there_sum - (AddrW+1)'(TableLen)) : there_sum[AddrW-1:0];
  assign rd_addr_a = (state_q == S_STEP_RD) ? idx_q : ptr_q;

  assign rem_sh  = {div_rem_q, div_dvd_q[15]};
  assign rem_nxt = (rem_sh >= {1'b0, bound_q}) ? 16'(rem_sh - {1'b0, bound_q})
                                               : rem_sh[15:0];

  assign diag_keep = AllOnes >> diag_q;
  assign diag_top  = TopBit >> diag_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_q;
    wr_data = step_word;
    case (state_q)
      S_FILL: begin
        wr_en   = 1'b1;
        wr_data = {1'b0, lcg_out};
      end
      S_MARK_WR: begin
        wr_en   = 1'b1;
        wr_data = word_a | ((lcg_out > MarkThresh) ? TopBit : 16'h0000);
      end
      S_DIAG_WR: begin
        wr_en   = 1'b1;
        wr_data = (word_a & diag_keep) | diag_top;
      end
      S_STEP_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    rd_a_q <= tbl_mem[rd_addr_a];
    rd_b_q <= tbl_mem[rd_addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q  <= '0;
      rd_a_vld_q <= 1'b0;
      rd_b_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        tbl_vld_q[wr_addr] <= 1'b1;
      end
      rd_a_vld_q <= tbl_vld_q[rd_addr_a];
      rd_b_vld_q <= tbl_vld_q[rd_addr_b];
    end
  end

  // control
  always_comb begin
    state_d     = state_q;
    lcg_d       = lcg_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    diag_d      = diag_q;
    bounded_d   = bounded_q;
    second_d    = second_q;
    div_mod_d   = div_mod_q;
    bound_d     = bound_q;
    limit_d     = limit_q;
    div_rem_d   = div_rem_q;
    div_dvd_d   = div_dvd_q;
    div_cnt_d   = div_cnt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d.value     = '0;
          res_d.bad_bound = 1'b0;
          case (in_data_i.action)
            ActReseed: begin
              lcg_d   = {16'h0000, seed_q};
              idx_d   = '0;
              ptr_d   = '0;
              state_d = S_FILL;
            end
            ActRaw: begin
              bounded_d = 1'b0;
              state_d   = S_STEP_RD;
            end
            ActBounded: begin
              if (in_data_i.bound == 16'h0000) begin
                res_d.bad_bound = 1'b1;
                state_d         = S_DONE;
              end else begin
                bound_d   = in_data_i.bound;
                bounded_d = 1'b1;
                second_d  = 1'b0;
                div_mod_d = 1'b0;
                div_rem_d = '0;
                div_dvd_d = AllOnes;
                div_cnt_d = '0;
                state_d   = S_DIV;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_FILL: begin
        lcg_d = lcg_nxt;
        if (ptr_q == AddrW'(TableLen - 1)) begin
          ptr_d   = '0;
          state_d = S_MARK_RD;
        end else begin
          ptr_d = ptr_q + AddrW'(1);
        end
      end
      S_MARK_RD: begin
        state_d = S_MARK_WR;
      end
      S_MARK_WR: begin
        lcg_d = lcg_nxt;
        if (ptr_q == AddrW'(TableLen - 1)) begin
          ptr_d   = AddrW'(DiagBase);
          diag_d  = '0;
          state_d = S_DIAG_RD;
        end else begin
          ptr_d   = ptr_q + AddrW'(1);
          state_d = S_MARK_RD;
        end
      end
      S_DIAG_RD: begin
        state_d = S_DIAG_WR;
      end
      S_DIAG_WR: begin
        if (diag_q == 4'(DiagCount - 1)) begin
          state_d = S_DONE;
        end else begin
          diag_d  = diag_q + 4'd1;
          ptr_d   = ptr_q + AddrW'(DiagStride);
          state_d = S_DIAG_RD;
        end
      end
      S_STEP_RD: begin
        state_d = S_STEP_WR;
      end
      S_STEP_WR: begin
        idx_d = (idx_q == AddrW'(TableLen - 1)) ? '0 : idx_q + AddrW'(1);
        if (!bounded_q) begin
          res_d.value = step_word;
          state_d     = S_DONE;
        end else if (!second_q) begin
          second_d = 1'b1;
          state_d  = S_STEP_RD;
        end else begin
          second_d = 1'b0;
          if (step_word >= limit_q) begin
            state_d = S_STEP_RD;
          end else begin
            div_mod_d = 1'b1;
            div_rem_d = '0;
            div_dvd_d = step_word;
            div_cnt_d = '0;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        div_rem_d = rem_nxt;
        div_dvd_d = {div_dvd_q[14:0], 1'b0};
        div_cnt_d = div_cnt_q + 4'd1;
        if (div_cnt_q == 4'd15) begin
          if (div_mod_q) begin
            res_d.value = rem_nxt;
            state_d     = S_DONE;
          end else begin
            limit_d = AllOnes - rem_nxt;
            state_d = S_STEP_RD;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seed_q      <= 16'h0001;
      lcg_q       <= 32'h0000_0001;
      idx_q       <= '0;
      ptr_q       <= '0;
      diag_q      <= '0;
      bounded_q   <= 1'b0;
      second_q    <= 1'b0;
      div_mod_q   <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lcg_q       <= lcg_d;
      idx_q       <= idx_d;
      ptr_q       <= ptr_d;
      diag_q      <= diag_d;
      bounded_q   <= bounded_d;
      second_q    <= second_d;
      div_mod_q   <= div_mod_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        seed_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bound_q    <= bound_d;
    limit_q    <= limit_d;
    div_rem_q  <= div_rem_d;
    div_dvd_q  <= div_dvd_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
